// File: hw/rtl/prc_pkg.sv
// shared types, constants and helper function of the pump run controller
package prc_pkg;

    localparam int TICKS_PER_MINUTE = 600;
    localparam int EMPTY_TRIGGER    = 20;
    localparam int STOP_TRIGGER     = 5;
    localparam int MIN_MINUTES      = 1;
    localparam int MAX_MINUTES      = 12;
    localparam int DEFAULT_MINUTES  = 3;

    localparam int MINUTES_W = 8;
    localparam int TIMER_W   = 14;
    localparam int EMPTY_W   = 5;
    localparam int STOP_W    = 3;
    localparam int EFF_W     = 4;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [MINUTES_W-1:0] MINUTES_RESET = MINUTES_W'(DEFAULT_MINUTES);
    localparam logic signed [TIMER_W-1:0] RELOAD_RESET =
        TIMER_W'(DEFAULT_MINUTES * TICKS_PER_MINUTE);

    typedef struct packed {
        logic button_pressed;
        logic tank_full;
        logic tank_empty;
    } tick_in_t;

    typedef struct packed {
        logic signed [TIMER_W-1:0] ticks_left;
        logic                      empty_indicator;
        logic                      full_indicator;
        logic                      pump_on;
    } tick_out_t;

    // run length in ticks for a given minutes setting, out of range acts as default
    function automatic logic signed [TIMER_W-1:0] reload_ticks(
        input logic [MINUTES_W-1:0] minutes
    );
        logic [EFF_W-1:0]   eff;
        logic [TIMER_W-1:0] prod;
        if ((minutes < MINUTES_W'(MIN_MINUTES)) || (minutes > MINUTES_W'(MAX_MINUTES))) begin
            eff = EFF_W'(DEFAULT_MINUTES);
        end else begin
            eff = minutes[EFF_W-1:0];
        end
        prod = TIMER_W'(eff) * TIMER_W'(TICKS_PER_MINUTE);
        return $signed(prod);
    endfunction

endpackage

// File: hw/rtl/prc_cfg.sv
// run length register, keeps the reload value in ticks ready
module prc_cfg (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [prc_pkg::MINUTES_W-1:0]         cfg_data,
    output logic signed [prc_pkg::TIMER_W-1:0]    reload_value
);

    logic signed [prc_pkg::TIMER_W-1:0] reload_reg;

    assign cfg_ready    = 1'b1;
    assign reload_value = reload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= prc_pkg::RELOAD_RESET;
        end else if (cfg_valid) begin
            reload_reg <= prc_pkg::reload_ticks(cfg_data);
        end
    end

endmodule

// File: hw/rtl/prc_core.sv
// pump state registers and the per-tick update logic
module prc_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  prc_pkg::tick_in_t                  tick_in,
    input  logic signed [prc_pkg::TIMER_W-1:0] reload_value,
    output prc_pkg::tick_out_t                 tick_out
);

    logic                               pump_reg, pump_next;
    logic                               manual_reg, manual_next;
    logic signed [prc_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [prc_pkg::EMPTY_W-1:0]        empty_reg, empty_next;
    logic [prc_pkg::STOP_W-1:0]         stop_reg, stop_next;

    always_comb begin
        pump_next   = pump_reg;
        manual_next = manual_reg;
        timer_next  = timer_reg;
        empty_next  = empty_reg;
        stop_next   = stop_reg;

        // long empty spell starts an idle pump
        if (tick_in.tank_empty) begin
            if (empty_reg >= prc_pkg::EMPTY_W'(prc_pkg::EMPTY_TRIGGER)) begin
                if (!pump_reg) begin
                    timer_next = reload_value;
                    pump_next  = 1'b1;
                end
                empty_next = prc_pkg::EMPTY_W'(1);
            end else begin
                empty_next = empty_reg + prc_pkg::EMPTY_W'(1);
            end
        end else begin
            empty_next = '0;
        end

        // manual button toggles
        if (tick_in.button_pressed) begin
            if (!manual_reg) begin
                manual_next = 1'b1;
                pump_next   = 1'b1;
            end else begin
                manual_next = 1'b0;
                pump_next   = 1'b0;
                timer_next  = reload_value;
            end
        end

        // count down and watch for the stop condition
        if (pump_next) begin
            timer_next = timer_next - prc_pkg::TIMER_W'(1);
            if (timer_next[prc_pkg::TIMER_W-1] || (timer_next == '0) || tick_in.tank_full) begin
                if (stop_reg + prc_pkg::STOP_W'(1) >= prc_pkg::STOP_W'(prc_pkg::STOP_TRIGGER)) begin
                    pump_next  = 1'b0;
                    stop_next  = '0;
                    timer_next = reload_value;
                end else begin
                    stop_next = stop_reg + prc_pkg::STOP_W'(1);
                end
            end else begin
                stop_next = '0;
            end
        end
    end

    always_comb begin
        tick_out.pump_on         = pump_next;
        tick_out.full_indicator  = tick_in.tank_full;
        tick_out.empty_indicator = tick_in.tank_empty;
        tick_out.ticks_left      = timer_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pump_reg   <= 1'b1;
            manual_reg <= 1'b0;
            timer_reg  <= prc_pkg::RELOAD_RESET;
            empty_reg  <= '0;
            stop_reg   <= '0;
        end else if (step) begin
            pump_reg   <= pump_next;
            manual_reg <= manual_next;
            timer_reg  <= timer_next;
            empty_reg  <= empty_next;
            stop_reg   <= stop_next;
        end
    end

endmodule

// File: hw/rtl/pump_run_controller.sv
// top level of the pump run controller: stream ports, input and result registers
// Water tank pump controller, one input transfer per tick. Each tick carries the
// tank-empty, tank-full and button levels; each produces exactly one result
// transfer with the pump drive, the two level lamps and the run timer value left
// after that tick. Twenty-one consecutive empty ticks start an idle pump with a
// fresh run timer, the button toggles a manual start/stop, and five consecutive
// running ticks with the timer at or below zero or the tank full stop the pump.
// The pump runs right after reset. A tick passes through the input register and
// then the result register; a new tick is taken every cycle while the result side
// is not stalled, set by the single state update that sits between the input
// register and the result register. The run length register may be written on
// the cfg channel while no tick is in flight; it takes effect at the next timer reload.
module pump_run_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input ticks
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [prc_pkg::IN_TDATA_W-1:0]      s_tdata,   // tank_empty, tank_full, button_pressed, zeros
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [prc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // pump_on, full_indicator, empty_indicator, ticks_left[13:0], zeros
    // run length register write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prc_pkg::MINUTES_W-1:0]       cfg_data
);

    logic                               in_valid_reg;
    prc_pkg::tick_in_t                  in_data_reg;
    logic                               out_valid_reg;
    prc_pkg::tick_out_t                 out_data_reg;
    prc_pkg::tick_out_t                 core_out;
    logic signed [prc_pkg::TIMER_W-1:0] reload_value;
    logic                               out_free;
    logic                               step;

    // result register can take a new item when empty or draining this cycle
    assign out_free = !out_valid_reg || m_tready;
    // input register moves on into the state update
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    prc_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .reload_value (reload_value)
    );

    prc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .tick_in      (in_data_reg),
        .reload_value (reload_value),
        .tick_out     (core_out)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg.tank_empty     <= s_tdata[0];
            in_data_reg.tank_full      <= s_tdata[1];
            in_data_reg.button_pressed <= s_tdata[2];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= core_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    always_comb begin
        m_tdata        = '0;
        m_tdata[0]     = out_data_reg.pump_on;
        m_tdata[1]     = out_data_reg.full_indicator;
        m_tdata[2]     = out_data_reg.empty_indicator;
        m_tdata[16:3]  = out_data_reg.ticks_left;
    end

endmodule
